FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the heartbeat watchdog RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks an implication whose consequent is sampled on the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: src/hbw_pkg.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog package
// Command, event and state codes and the per-channel record types.
// ---------------------------------------------------------------------------
package hbw_pkg;

    typedef enum logic [1:0] {
        CMD_HEARTBEAT = 2'd0,
        CMD_CHECK     = 2'd1,
        CMD_RESET     = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        EV_ON      = 2'd0,
        EV_SHUTOFF = 2'd1,
        EV_RESET   = 2'd2,
        EV_INVALID = 2'd3
    } ev_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic        active;
        logic [31:0] source;
        logic [31:0] seq;
        logic [31:0] last_ms;
    } chan_t;

    typedef struct packed {
        logic [1:0]  event_code;
        logic [4:0]  channel;
        logic        new_source;
        logic        sequence_gap;
        logic [31:0] elapsed;
        logic [31:0] last_seen;
        logic [31:0] source;
    } res_t;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

endpackage

FILE: src/hbw_if.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog channel interfaces
// Valid/ready channels for commands, events and the timeout register.
// ---------------------------------------------------------------------------
interface hbw_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [4:0]  channel_number;
    logic [31:0] source_tag;
    logic [31:0] sequence_number;
    logic [31:0] now_ms;

    modport source (
        output valid, command, channel_number, source_tag, sequence_number, now_ms,
        input  ready
    );
    modport sink (
        input  valid, command, channel_number, source_tag, sequence_number, now_ms,
        output ready
    );
endinterface

interface hbw_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_code;
    logic [4:0]  channel_out;
    logic        new_source;
    logic        sequence_gap;
    logic [31:0] elapsed_out;
    logic [31:0] last_seen_ms;
    logic [31:0] source_out;
    logic        last_result;

    modport source (
        output valid, event_code, channel_out, new_source, sequence_gap,
               elapsed_out, last_seen_ms, source_out, last_result,
        input  ready
    );
    modport sink (
        input  valid, event_code, channel_out, new_source, sequence_gap,
               elapsed_out, last_seen_ms, source_out, last_result,
        output ready
    );
endinterface

interface hbw_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] timeout_ms;

    modport source (
        output valid, timeout_ms,
        input  ready
    );
    modport sink (
        input  valid, timeout_ms,
        output ready
    );
endinterface

FILE: src/hbw_cell.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog ring cell
// Holds one channel record and passes it to its neighbor on each ring step.
// ---------------------------------------------------------------------------
module hbw_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  hbw_pkg::chan_t din,
    output hbw_pkg::chan_t dout
);
    import hbw_pkg::*;

    chan_t chan_reg;
    chan_t chan_next;

    always_comb
    begin
        chan_next = shift_en ? din : chan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
        end
        else
        begin
            chan_reg <= chan_next;
        end
    end

    assign dout = chan_reg;

endmodule

FILE: src/hbw_ctrl.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog controller
// Sequences one full ring rotation per command, updates the channel at the
// ring head, and queues events so the final one carries the last flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hbw_ctrl #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    hbw_cmd_if.sink        cmd,
    hbw_evt_if.source      evt,
    hbw_cfg_if.sink        cfg,
    input  hbw_pkg::chan_t head,
    output hbw_pkg::chan_t tail,
    output logic           shift_en
);
    import hbw_pkg::*;

    localparam int PW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(NUM_CHANNELS - 1);

    state_t      state_reg;
    state_t      state_next;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    cmd_t        cmd_reg;
    logic [4:0]  ch_reg;
    logic [31:0] src_reg;
    logic [31:0] seq_reg;
    logic [31:0] now_reg;
    logic [31:0] timeout_reg;
    logic        pend_valid_reg;
    res_t        pend_reg;
    logic        out_valid_reg;
    res_t        out_reg;
    logic        out_last_reg;

    logic        accept;
    logic        ch_ok;
    logic        match;
    logic [31:0] elapsed;
    logic        res_hit;
    res_t        res;
    logic        out_free;
    logic        fin_hit;
    res_t        fin_res;
    logic        step;
    logic        out_load;
    res_t        out_data;
    logic        out_last;

    assign accept   = cmd.valid && cmd.ready;
    assign ch_ok    = (ch_reg != 5'd0) && (ch_reg <= 5'(NUM_CHANNELS));
    assign match    = ch_ok && (ch_reg == (5'(pos_reg) + 5'd1));
    assign elapsed  = now_reg - head.last_ms;
    assign out_free = !out_valid_reg || evt.ready;

    // Update of the channel record that sits at the ring head.
    always_comb
    begin
        tail    = head;
        res_hit = 1'b0;
        res     = '0;
        res.channel = 5'(pos_reg) + 5'd1;
        case (cmd_reg)
            CMD_HEARTBEAT:
            begin
                if (match)
                begin
                    res_hit          = 1'b1;
                    res.event_code   = EV_ON;
                    res.new_source   = !head.active || (head.source != src_reg);
                    res.sequence_gap = (head.seq != 32'd0) && (seq_reg != head.seq + 32'd1);
                    tail.active      = 1'b1;
                    tail.source      = src_reg;
                    tail.seq         = seq_reg;
                    tail.last_ms     = now_reg;
                end
            end
            CMD_RESET:
            begin
                if (match)
                begin
                    res_hit        = 1'b1;
                    res.event_code = EV_RESET;
                    tail           = '0;
                end
            end
            CMD_CHECK:
            begin
                if (head.active && (elapsed > timeout_reg))
                begin
                    res_hit        = 1'b1;
                    res.event_code = EV_SHUTOFF;
                    res.elapsed    = elapsed;
                    res.last_seen  = head.last_ms;
                    res.source     = head.source;
                    tail           = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        fin_hit = pend_valid_reg
            || (!ch_ok && ((cmd_reg == CMD_HEARTBEAT) || (cmd_reg == CMD_RESET)));
        if (pend_valid_reg)
        begin
            fin_res = pend_reg;
        end
        else
        begin
            fin_res            = '0;
            fin_res.event_code = EV_INVALID;
            fin_res.channel    = ch_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step && (pos_reg == LAST_POS))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!fin_hit || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready = 1'b0;
        step      = 1'b0;
        out_load  = 1'b0;
        out_data  = pend_reg;
        out_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_SCAN:
            begin
                step     = !res_hit || !pend_valid_reg || out_free;
                out_load = step && res_hit && pend_valid_reg;
            end
            ST_FLUSH:
            begin
                out_load = fin_hit && out_free;
                out_data = fin_res;
                out_last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign shift_en = step;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = '0;
        end
        else if (step)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.timeout_ms;
            end
            if (step && res_hit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if ((state_reg == ST_FLUSH) && (state_next == ST_IDLE))
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd.command);
            ch_reg  <= cmd.channel_number;
            src_reg <= cmd.source_tag;
            seq_reg <= cmd.sequence_number;
            now_reg <= cmd.now_ms;
        end
        if (step && res_hit)
        begin
            pend_reg <= res;
        end
        if (out_load)
        begin
            out_reg      <= out_data;
            out_last_reg <= out_last;
        end
    end

    assign cfg.ready        = 1'b1;
    assign evt.valid        = out_valid_reg;
    assign evt.event_code   = out_reg.event_code;
    assign evt.channel_out  = out_reg.channel;
    assign evt.new_source   = out_reg.new_source;
    assign evt.sequence_gap = out_reg.sequence_gap;
    assign evt.elapsed_out  = out_reg.elapsed;
    assign evt.last_seen_ms = out_reg.last_seen;
    assign evt.source_out   = out_reg.source;
    assign evt.last_result  = out_last_reg;

    `ASSERT_CLK(a_idle_no_pending, clk, rst_n,
        (state_reg == ST_IDLE) |-> !pend_valid_reg,
        "Pending event left over after a command finished")
    `ASSERT_CLK(a_idle_ring_aligned, clk, rst_n,
        (state_reg == ST_IDLE) |-> (pos_reg == '0),
        "Ring position not aligned while idle")
    `ASSERT_NEXT(a_scan_to_flush, clk, rst_n,
        (state_reg == ST_SCAN) && step && (pos_reg == LAST_POS),
        state_reg == ST_FLUSH,
        "Scan did not end after a full ring rotation")
    `ASSERT_CLK(a_shutoff_only_on_check, clk, rst_n,
        (out_load && (out_data.event_code == EV_SHUTOFF)) |-> (cmd_reg == CMD_CHECK),
        "Safety shutoff issued outside a check command")
    `ASSERT_CLK(a_no_overwrite, clk, rst_n,
        out_load |-> out_free,
        "Event register overwritten before transfer")

endmodule

FILE: src/multi_channel_heartbeat_watchdog.sv
// ---------------------------------------------------------------------------
// Multi-channel heartbeat watchdog
// Per-channel heartbeat supervision with timeout shutoff of relay outputs.
// ---------------------------------------------------------------------------
// Each command transfer is accepted, then the ring of channel records rotates
// once past the update logic at its head, and then the final event is
// released. Rotation and release wait while the sink holds back the event
// in the output register and another event is waiting to enter it.
// A new command is taken once the previous one has released its final event
// into the output register.
module multi_channel_heartbeat_watchdog #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    hbw_cmd_if.sink   cmd,
    hbw_evt_if.source evt,
    hbw_cfg_if.sink   cfg
);
    import hbw_pkg::*;

    chan_t cell_q [NUM_CHANNELS];
    chan_t tail;
    logic  shift_en;

    for (genvar k = 0; k < NUM_CHANNELS; k++)
    begin : g_ring
        if (k == NUM_CHANNELS - 1)
        begin : g_last
            hbw_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .din      (tail),
                .dout     (cell_q[k])
            );
        end
        else
        begin : g_mid
            hbw_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .din      (cell_q[k+1]),
                .dout     (cell_q[k])
            );
        end
    end

    hbw_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .evt      (evt),
        .cfg      (cfg),
        .head     (cell_q[0]),
        .tail     (tail),
        .shift_en (shift_en)
    );

endmodule

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// Heartbeat watchdog testbench
// Drives heartbeat, check, reset and no-op commands into the watchdog, with idle
// gaps on the command side and stalls on the event side. Every accepted
// command transfer is run through a behavioral copy of the channel table,
// and each event transfer is compared field by field with the oldest
// outstanding expected event. The run starts with a short table of directed
// commands and then walks several timeout settings with random traffic.
// ---------------------------------------------------------------------------
module tb_top;
    import hbw_pkg::*;

    localparam int NUM_CH = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT = 20000;
    localparam int LIMIT_CYCLES = 400000;
    localparam int NUM_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 38;
    localparam int NUM_ROWS = 25;

    typedef struct packed {
        cmd_t        command;
        logic [4:0]  channel;
        logic [31:0] source;
        logic [31:0] seq;
        logic [31:0] now;
    } cmd_item_t;

    typedef struct packed {
        res_t body;
        logic last;
    } watch_event_t;

    typedef struct {
        cmd_item_t item;
        bit        typed;
        ev_t       code;
        logic      new_src;
        logic      gap;
    } step_row_t;

    logic clk;
    logic rst_n;

    hbw_cmd_if cmd_if ();
    hbw_evt_if evt_if ();
    hbw_cfg_if cfg_if ();

    multi_channel_heartbeat_watchdog #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .evt   (evt_if),
        .cfg   (cfg_if)
    );

    logic        chan_live   [NUM_CH];
    logic [31:0] chan_source [NUM_CH];
    logic [31:0] chan_seq    [NUM_CH];
    logic [31:0] chan_seen   [NUM_CH];
    logic [31:0] watch_timeout;

    logic [31:0] sender_src [NUM_CH];
    logic [31:0] sender_seq [NUM_CH];
    logic [31:0] clock_ms;
    logic [31:0] time_step;

    logic [31:0] phase_timeout [NUM_PHASES];
    logic [31:0] phase_step    [NUM_PHASES];
    step_row_t   directed_rows [NUM_ROWS];

    watch_event_t pending_events[$];
    watch_event_t observed_ev;
    watch_event_t wanted_ev;

    int unsigned burst_left;
    int unsigned fault_count;
    int unsigned cycle_count;

    always #1 clk = ~clk;

    function automatic void watchdog_step(input cmd_item_t it, ref watch_event_t produced[$]);
        watch_event_t ev;
        int unsigned  idx;
        logic [31:0]  elapsed;
        bit           in_range;
        in_range = (it.channel >= 5'd1) && (it.channel <= NUM_CH);
        ev = '0;
        if (it.command == CMD_HEARTBEAT || it.command == CMD_RESET)
        begin
            ev.body.channel = it.channel;
            if (!in_range)
            begin
                ev.body.event_code = EV_INVALID;
            end
            else if (it.command == CMD_HEARTBEAT)
            begin
                idx = it.channel - 1;
                ev.body.event_code = EV_ON;
                if (!chan_live[idx] || chan_source[idx] != it.source)
                begin
                    chan_live[idx] = 1'b1;
                    chan_source[idx] = it.source;
                    ev.body.new_source = 1'b1;
                end
                if (chan_seq[idx] != 32'd0 && it.seq != chan_seq[idx] + 32'd1)
                    ev.body.sequence_gap = 1'b1;
                chan_seq[idx] = it.seq;
                chan_seen[idx] = it.now;
            end
            else
            begin
                idx = it.channel - 1;
                ev.body.event_code = EV_RESET;
                chan_live[idx] = 1'b0;
                chan_source[idx] = '0;
                chan_seq[idx] = '0;
                chan_seen[idx] = '0;
            end
            produced.push_back(ev);
        end
        else if (it.command == CMD_CHECK)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                elapsed = it.now - chan_seen[i];
                if (chan_live[i] && elapsed > watch_timeout)
                begin
                    ev = '0;
                    ev.body.event_code = EV_SHUTOFF;
                    ev.body.channel = 5'(i + 1);
                    ev.body.elapsed = elapsed;
                    ev.body.last_seen = chan_seen[i];
                    ev.body.source = chan_source[i];
                    produced.push_back(ev);
                    chan_live[i] = 1'b0;
                    chan_source[i] = '0;
                    chan_seq[i] = '0;
                    chan_seen[i] = '0;
                end
            end
        end
        if (produced.size() > 0)
            produced[produced.size() - 1].last = 1'b1;
    endfunction

    function automatic bit same_event(input watch_event_t a, input watch_event_t b);
        return a.body.event_code == b.body.event_code
            && a.body.channel == b.body.channel
            && a.body.new_source == b.body.new_source
            && a.body.sequence_gap == b.body.sequence_gap
            && a.body.elapsed == b.body.elapsed
            && a.body.last_seen == b.body.last_seen
            && a.body.source == b.body.source
            && a.last == b.last;
    endfunction

    function automatic string event_text(input watch_event_t e);
        return $sformatf("code %0d ch %0d new %0b gap %0b el %h seen %h src %h last %0b",
            e.body.event_code, e.body.channel, e.body.new_source, e.body.sequence_gap,
            e.body.elapsed, e.body.last_seen, e.body.source, e.last);
    endfunction

    task automatic issue_command(input cmd_item_t it, input bit typed, input watch_event_t typed_ev);
        watch_event_t produced[$];
        int unsigned  gap_len;
        if (burst_left == 0)
        begin
            gap_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : $urandom_range(0, 2);
            if (gap_len > 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_if.valid <= 1'b1;
        cmd_if.command <= it.command;
        cmd_if.channel_number <= it.channel;
        cmd_if.source_tag <= it.source;
        cmd_if.sequence_number <= it.seq;
        cmd_if.now_ms <= it.now;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        watchdog_step(it, produced);
        if (typed)
        begin
            produced.delete();
            produced.push_back(typed_ev);
        end
        foreach (produced[k])
            pending_events.push_back(produced[k]);
    endtask

    task automatic settle();
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        settle();
        cfg_if.valid <= 1'b1;
        cfg_if.timeout_ms <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        watch_timeout = value;
    endtask

    task automatic random_command(output bit counted);
        cmd_item_t   it;
        int unsigned pick;
        int unsigned idx;
        int unsigned flavor;
        clock_ms += (time_step == 0) ? $urandom : $urandom_range(0, time_step);
        it.command = CMD_HEARTBEAT;
        it.channel = 5'($urandom_range(1, NUM_CH));
        it.source = $urandom;
        it.seq = $urandom;
        it.now = clock_ms;
        counted = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            idx = it.channel - 1;
            flavor = $urandom_range(0, 99);
            if (flavor < 8)
                sender_src[idx] = $urandom;
            if (flavor >= 8 && flavor < 16)
                sender_seq[idx] = $urandom;
            else
                sender_seq[idx] = sender_seq[idx] + 32'd1;
            it.source = sender_src[idx];
            it.seq = sender_seq[idx];
        end
        else if (pick < 75)
        begin
            it.command = CMD_CHECK;
        end
        else if (pick < 83)
        begin
            it.command = CMD_RESET;
        end
        else if (pick < 93)
        begin
            it.command = ($urandom_range(0, 1) == 0) ? CMD_HEARTBEAT : CMD_RESET;
            it.channel = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(NUM_CH + 1, 31));
        end
        else
        begin
            it.command = CMD_NONE;
            it.channel = 5'($urandom_range(0, 31));
            counted = 1'b0;
        end
        issue_command(it, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 97) % 4)
            0: evt_if.ready <= 1'b1;
            1: evt_if.ready <= 1'($urandom_range(0, 1));
            2: evt_if.ready <= (cycle_count % 7) < 4;
            default: evt_if.ready <= ($urandom_range(0, 5) == 0);
        endcase
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && evt_if.valid && evt_if.ready)
        begin
            observed_ev.body.event_code = evt_if.event_code;
            observed_ev.body.channel = evt_if.channel_out;
            observed_ev.body.new_source = evt_if.new_source;
            observed_ev.body.sequence_gap = evt_if.sequence_gap;
            observed_ev.body.elapsed = evt_if.elapsed_out;
            observed_ev.body.last_seen = evt_if.last_seen_ms;
            observed_ev.body.source = evt_if.source_out;
            observed_ev.last = evt_if.last_result;
            if (pending_events.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected event: %s", event_text(observed_ev));
            end
            else
            begin
                wanted_ev = pending_events.pop_front();
                if (!same_event(wanted_ev, observed_ev))
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("event mismatch: expected %s, got %s",
                            event_text(wanted_ev), event_text(observed_ev));
                end
            end
        end
    end

    initial
    begin
        watch_event_t typed_ev;
        bit           counted;
        int unsigned  done;
        int unsigned  waited;
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_NONE;
        cmd_if.channel_number = '0;
        cmd_if.source_tag = '0;
        cmd_if.sequence_number = '0;
        cmd_if.now_ms = '0;
        evt_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.timeout_ms = '0;
        watch_timeout = TIMEOUT_RESET;
        burst_left = 0;
        fault_count = 0;
        cycle_count = 0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            chan_live[i] = 1'b0;
            chan_source[i] = '0;
            chan_seq[i] = '0;
            chan_seen[i] = '0;
            sender_src[i] = $urandom;
            sender_seq[i] = $urandom;
        end

        directed_rows = '{
            '{'{CMD_HEARTBEAT, 5'd0, 32'h0, 32'h0, 32'h0}, 1, EV_INVALID, 0, 0},
            '{'{CMD_HEARTBEAT, 5'd31, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
                1, EV_INVALID, 0, 0},
            '{'{CMD_RESET, 5'd17, 32'h0, 32'h0, 32'h0}, 1, EV_INVALID, 0, 0},
            '{'{CMD_RESET, 5'd0, 32'h0, 32'h0, 32'h0}, 1, EV_INVALID, 0, 0},
            '{'{CMD_CHECK, 5'd0, 32'h0, 32'h0, 32'hFFFFFFFF}, 0, EV_ON, 0, 0},
            '{'{CMD_NONE, 5'd5, 32'h1234, 32'h5, 32'h7}, 0, EV_ON, 0, 0},
            '{'{CMD_HEARTBEAT, 5'd1, 32'hFFFFFFFF, 32'd0, 32'd0}, 1, EV_ON, 1, 0},
            '{'{CMD_HEARTBEAT, 5'd1, 32'hFFFFFFFF, 32'd5, 32'd10}, 1, EV_ON, 0, 0},
            '{'{CMD_HEARTBEAT, 5'd1, 32'hFFFFFFFF, 32'd7, 32'd20}, 1, EV_ON, 0, 1},
            '{'{CMD_HEARTBEAT, 5'd1, 32'h0, 32'd8, 32'd30}, 1, EV_ON, 1, 0},
            '{'{CMD_HEARTBEAT, 5'd16, 32'hA5A5A5A5, 32'hFFFFFFFF, 32'hFFFFFF00},
                1, EV_ON, 1, 0},
            '{'{CMD_HEARTBEAT, 5'd16, 32'hA5A5A5A5, 32'd0, 32'h100}, 1, EV_ON, 0, 0},
            '{'{CMD_HEARTBEAT, 5'd8, 32'h12345678, 32'd1, 32'd500}, 1, EV_ON, 1, 0},
            '{'{CMD_CHECK, 5'd0, 32'h0, 32'h0, 32'd1030}, 0, EV_ON, 0, 0},
            '{'{CMD_CHECK, 5'd0, 32'h0, 32'h0, 32'd1031}, 0, EV_ON, 0, 0},
            '{'{CMD_RESET, 5'd8, 32'h0, 32'h0, 32'h0}, 1, EV_RESET, 0, 0},
            '{'{CMD_RESET, 5'd16, 32'h0, 32'h0, 32'h0}, 1, EV_RESET, 0, 0},
            '{'{CMD_RESET, 5'd16, 32'h0, 32'h0, 32'h0}, 1, EV_RESET, 0, 0},
            '{'{CMD_HEARTBEAT, 5'd3, 32'd1, 32'd2, 32'hFFFFFFF0}, 1, EV_ON, 1, 0},
            '{'{CMD_CHECK, 5'd0, 32'h0, 32'h0, 32'h400}, 0, EV_ON, 0, 0},
            '{'{CMD_HEARTBEAT, 5'd2, 32'd2, 32'd3, 32'd0}, 1, EV_ON, 1, 0},
            '{'{CMD_HEARTBEAT, 5'd15, 32'h5555AAAA, 32'd9, 32'd0}, 1, EV_ON, 1, 0},
            '{'{CMD_HEARTBEAT, 5'd4, 32'd3, 32'd4, 32'd2000}, 1, EV_ON, 1, 0},
            '{'{CMD_CHECK, 5'd0, 32'h0, 32'h0, 32'd1500}, 0, EV_ON, 0, 0},
            '{'{CMD_CHECK, 5'd0, 32'h0, 32'h0, 32'd1500}, 0, EV_ON, 0, 0}
        };

        phase_timeout = '{32'd1000, 32'd0, 32'hFFFFFFFF, 32'd1, 32'($urandom_range(20, 200))};
        phase_step = '{32'd300, 32'd2, 32'd0, 32'd3, 32'd0};
        phase_step[4] = phase_timeout[4] / 3;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            typed_ev = '0;
            typed_ev.body.event_code = directed_rows[r].code;
            typed_ev.body.channel = directed_rows[r].item.channel;
            typed_ev.body.new_source = directed_rows[r].new_src;
            typed_ev.body.sequence_gap = directed_rows[r].gap;
            typed_ev.last = 1'b1;
            issue_command(directed_rows[r].item, directed_rows[r].typed, typed_ev);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_timeout(phase_timeout[p]);
            time_step = phase_step[p];
            clock_ms = $urandom;
            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                random_command(counted);
                if (counted)
                    done++;
            end
        end

        cmd_if.valid <= 1'b0;
        waited = 0;
        while (pending_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            fault_count++;
            $display("%0d expected events never arrived", pending_events.size());
        end

        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
